// ===== src/psvb_pkg.sv =====
// ----------------------------------------------------------------------------
// psvb_pkg: shared types, constants and microcode for the string voice bank
// Holds field widths, the noise generator functions, the control word format
// and the read-only program that the sequencer steps through.
// ----------------------------------------------------------------------------
package psvb_pkg;

  // Parameter defaults.
  localparam int VOICES_DEF      = 8;
  localparam int LOOP_DEPTH_DEF  = 1024;
  localparam int NOISE_DEPTH_DEF = 256;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int PLEN_W   = 11;
  localparam int MIX_W    = 20;
  localparam int GAIN_W   = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd64881;

  // Noise generator: 16-bit Galois LFSR.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // Program steps.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_V_READ_P,
    ST_V_READ_N,
    ST_V_MUL,
    ST_V_WRITE,
    ST_V_SKIP,
    ST_EMIT,
    ST_P_START,
    ST_P_FILL,
    ST_P_DONE
  } step_t;

  // Branch conditions.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_MODE_PLUCK,
    COND_LEN_ZERO,
    COND_MORE_VOICES,
    COND_OUT_BUSY,
    COND_PLEN_ZERO,
    COND_FILL_MORE
  } cond_t;

  // Datapath operations, one bit each.
  typedef struct packed {
    logic take;        // offer to accept an item
    logic rd_n;        // read the next slot instead of the current one
    logic cap_a;       // capture the current slot sample
    logic mul;         // feedback product of the slot pair
    logic wr_fb;       // write feedback, accumulate, advance the position
    logic voice_next;  // step to the next voice
    logic emit;        // load the output register
    logic pluck_init;  // start a refill
    logic fill_wr;     // write one noise sample
    logic pluck_done;  // commit loop length and position
  } ops_t;

  // Status returned from the datapath for branching.
  typedef struct packed {
    logic no_item;
    logic mode_pluck;
    logic len_zero;
    logic more_voices;
    logic out_busy;
    logic plen_zero;
    logic fill_more;
  } status_t;

  typedef struct packed {
    ops_t  ops;
    cond_t cond;
    step_t target_t;
    step_t target_f;
  } ucode_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    logic [15:0] s;
    s = {1'b0, l[15:1]};
    if (l[0]) begin
      s = s ^ LFSR_MASK;
    end
    return s;
  endfunction

  // Halve the LFSR word read as signed.
  function automatic logic signed [SAMPLE_W-1:0] noise_sample(input logic [15:0] l);
    return {l[15], l[15:1]};
  endfunction

  // The control program.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w.ops      = '0;
    w.cond     = COND_ALWAYS;
    w.target_t = ST_IDLE;
    w.target_f = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.ops.take = 1'b1;
        w.cond     = COND_NO_ITEM;
        w.target_t = ST_IDLE;
        w.target_f = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        w.cond     = COND_MODE_PLUCK;
        w.target_t = ST_P_START;
        w.target_f = ST_V_READ_P;
      end
      ST_V_READ_P: begin
        w.cond     = COND_LEN_ZERO;
        w.target_t = ST_V_SKIP;
        w.target_f = ST_V_READ_N;
      end
      ST_V_READ_N: begin
        w.ops.rd_n  = 1'b1;
        w.ops.cap_a = 1'b1;
        w.target_t  = ST_V_MUL;
        w.target_f  = ST_V_MUL;
      end
      ST_V_MUL: begin
        w.ops.mul  = 1'b1;
        w.target_t = ST_V_WRITE;
        w.target_f = ST_V_WRITE;
      end
      ST_V_WRITE: begin
        w.ops.wr_fb      = 1'b1;
        w.ops.voice_next = 1'b1;
        w.cond           = COND_MORE_VOICES;
        w.target_t       = ST_V_READ_P;
        w.target_f       = ST_EMIT;
      end
      ST_V_SKIP: begin
        w.ops.voice_next = 1'b1;
        w.cond           = COND_MORE_VOICES;
        w.target_t       = ST_V_READ_P;
        w.target_f       = ST_EMIT;
      end
      ST_EMIT: begin
        w.ops.emit = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target_t = ST_EMIT;
        w.target_f = ST_IDLE;
      end
      ST_P_START: begin
        w.ops.pluck_init = 1'b1;
        w.cond           = COND_PLEN_ZERO;
        w.target_t       = ST_P_DONE;
        w.target_f       = ST_P_FILL;
      end
      ST_P_FILL: begin
        w.ops.fill_wr = 1'b1;
        w.cond        = COND_FILL_MORE;
        w.target_t    = ST_P_FILL;
        w.target_f    = ST_P_DONE;
      end
      ST_P_DONE: begin
        w.ops.pluck_done = 1'b1;
        w.target_t       = ST_IDLE;
        w.target_f       = ST_IDLE;
      end
      default: begin
        w.target_t = ST_IDLE;
        w.target_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/psvb_seq.sv =====
// ----------------------------------------------------------------------------
// psvb_seq: microcode sequencer
// Steps through the control program, one control word per cycle, and picks
// the taken or fall-back target from a datapath status flag.
// ----------------------------------------------------------------------------
module psvb_seq (
  input  logic              clk,
  input  logic              rst,
  input  psvb_pkg::status_t status,
  output psvb_pkg::ops_t    ops
);
  import psvb_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    word = ucode_rom(step);
    case (word.cond)
      COND_ALWAYS:      cond_true = 1'b1;
      COND_NO_ITEM:     cond_true = status.no_item;
      COND_MODE_PLUCK:  cond_true = status.mode_pluck;
      COND_LEN_ZERO:    cond_true = status.len_zero;
      COND_MORE_VOICES: cond_true = status.more_voices;
      COND_OUT_BUSY:    cond_true = status.out_busy;
      COND_PLEN_ZERO:   cond_true = status.plen_zero;
      COND_FILL_MORE:   cond_true = status.fill_more;
      default:          cond_true = 1'b0;
    endcase
    step_next = cond_true ? word.target_t : word.target_f;
    ops       = word.ops;
  end

endmodule

// ===== src/psvb_dpath.sv =====
// ----------------------------------------------------------------------------
// psvb_dpath: voice bank datapath
// Delay memory, per-voice position and length registers, noise generator,
// feedback multiplier, mix accumulator and output register.
// ----------------------------------------------------------------------------
module psvb_dpath #(
  parameter int VOICES      = psvb_pkg::VOICES_DEF,
  parameter int LOOP_DEPTH  = psvb_pkg::LOOP_DEPTH_DEF,
  parameter int NOISE_DEPTH = psvb_pkg::NOISE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psvb_pkg::ops_t                      ops,
  output psvb_pkg::status_t                   status,
  input  logic [psvb_pkg::GAIN_W-1:0]         decay_gain,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [psvb_pkg::PLEN_W-1:0]         period_length,
  input  logic signed [psvb_pkg::SAMPLE_W-1:0] mix_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psvb_pkg::MIX_W-1:0]   mix_out
);
  import psvb_pkg::*;

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW        = $clog2(LOOP_DEPTH);
  localparam int LW        = $clog2(LOOP_DEPTH + 1);
  localparam int CW        = LW + 1;
  localparam int NW        = $clog2(NOISE_DEPTH);
  localparam int PW        = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int ACC_RAW   = SAMPLE_W + $clog2(VOICES + 1);
  localparam int ACC_W     = (ACC_RAW > MIX_W + 1) ? ACC_RAW : MIX_W + 1;
  localparam int MEM_DEPTH = 1 << (VW + AW);
  localparam int PROD_W    = 2 * (SAMPLE_W + 1);

  localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'((1 <<< (MIX_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] MIX_MIN = -ACC_W'(1 <<< (MIX_W - 1));

  // Per-voice control state.
  logic [VW-1:0] v;
  logic [VW-1:0] next_voice;
  logic [AW-1:0] pos_q [VOICES];
  logic [LW-1:0] len_q [VOICES];

  // Item and working registers.
  logic                       mode_q;
  logic [LW-1:0]              plen_q;
  logic signed [ACC_W-1:0]    acc;
  logic [AW-1:0]              fill_idx;
  logic [NW-1:0]              noise_idx;
  logic [15:0]                lfsr;
  logic signed [SAMPLE_W-1:0] samp_a;
  logic signed [PROD_W-1:0]   prod;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;

  logic                       take_fire;
  logic [AW-1:0]              cur_pos;
  logic [LW-1:0]              cur_len;
  logic [CW-1:0]              pos_inc;
  logic [AW-1:0]              nxt_pos;
  logic [VW+AW-1:0]           raddr;
  logic [VW+AW-1:0]           waddr;
  logic                       we;
  logic signed [SAMPLE_W-1:0] wdata;
  logic signed [SAMPLE_W-1:0] fb;
  logic signed [SAMPLE_W-1:0] out_samp;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   gain_s;
  logic [15:0]                lstep;
  logic [PW-1:0]              plen_ext;
  logic [PW-1:0]              plen_clamp;
  logic signed [MIX_W-1:0]    mix_sat;

  always_comb begin
    take_fire  = ops.take & in_valid;
    in_stall   = ~ops.take;
    cur_pos    = pos_q[v];
    cur_len    = len_q[v];
    pos_inc    = CW'(cur_pos) + CW'(1);
    nxt_pos    = (pos_inc >= CW'(cur_len)) ? '0 : AW'(pos_inc);
    raddr      = {v, (ops.rd_n ? nxt_pos : cur_pos)};
    fb         = prod[SAMPLE_W+16:17];
    out_samp   = (cur_len == LW'(1)) ? fb : samp_a;
    pair_sum   = {samp_a[SAMPLE_W-1], samp_a} + {rdata[SAMPLE_W-1], rdata};
    gain_s     = {1'b0, decay_gain};
    lstep      = lfsr_step(lfsr);
    we         = ops.wr_fb | ops.fill_wr;
    waddr      = ops.fill_wr ? {v, fill_idx} : {v, nxt_pos};
    wdata      = ops.fill_wr ? noise_sample(lstep) : fb;
    plen_ext   = PW'(period_length);
    plen_clamp = (plen_ext > PW'(LOOP_DEPTH)) ? PW'(LOOP_DEPTH) : plen_ext;
    if (acc > MIX_MAX) begin
      mix_sat = MIX_MAX[MIX_W-1:0];
    end else if (acc < MIX_MIN) begin
      mix_sat = MIX_MIN[MIX_W-1:0];
    end else begin
      mix_sat = acc[MIX_W-1:0];
    end

    status.no_item     = ~in_valid;
    status.mode_pluck  = mode_q;
    status.len_zero    = (cur_len == '0);
    status.more_voices = (v != VW'(VOICES - 1));
    status.out_busy    = out_valid & out_stall;
    status.plen_zero   = (plen_q == '0);
    status.fill_more   = ((CW'(fill_idx) + CW'(1)) != CW'(plen_q));
  end

  // Delay memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      next_voice <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        pos_q[i] <= '0;
        len_q[i] <= '0;
      end
    end else begin
      if (take_fire) begin
        v <= '0;
      end else if (ops.pluck_init) begin
        v <= next_voice;
      end else if (ops.voice_next) begin
        v <= status.more_voices ? v + VW'(1) : '0;
      end
      if (ops.wr_fb) begin
        pos_q[v] <= nxt_pos;
      end
      if (ops.pluck_done) begin
        len_q[v]   <= plen_q;
        pos_q[v]   <= '0;
        next_voice <= (next_voice == VW'(VOICES - 1)) ? '0 : next_voice + VW'(1);
      end
      if (ops.emit && !status.out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (take_fire) begin
      mode_q <= mode;
      plen_q <= LW'(plen_clamp);
      acc    <= ACC_W'(mix_in);
    end else if (ops.wr_fb) begin
      acc <= acc + ACC_W'(out_samp);
    end
    if (ops.cap_a) begin
      samp_a <= rdata;
    end
    if (ops.mul) begin
      prod <= pair_sum * gain_s;
    end
    if (ops.pluck_init) begin
      lfsr      <= LFSR_SEED;
      noise_idx <= '0;
      fill_idx  <= '0;
    end else if (ops.fill_wr) begin
      fill_idx <= fill_idx + AW'(1);
      if (noise_idx == NW'(NOISE_DEPTH - 1)) begin
        lfsr      <= LFSR_SEED;
        noise_idx <= '0;
      end else begin
        lfsr      <= lstep;
        noise_idx <= noise_idx + NW'(1);
      end
    end
    if (ops.emit && !status.out_busy) begin
      mix_out <= mix_sat;
    end
  end

`ifndef ASSERT_OFF
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    take_fire |=> !ops.take)
    else $error("item accepted in the cycle after an accepted item");

  a_pos_in_loop: assert property (@(posedge clk) disable iff (rst)
    (cur_len == '0) || (CW'(cur_pos) < CW'(cur_len)))
    else $error("read position outside the voice loop");

  a_wr_live_voice: assert property (@(posedge clk) disable iff (rst)
    ops.wr_fb |-> (cur_len != '0))
    else $error("feedback write to a silent voice");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ops.fill_wr |-> (CW'(fill_idx) < CW'(plen_q)))
    else $error("refill ran past the loop length");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (ops.emit && !status.out_busy) |=> out_valid)
    else $error("emit did not load the output register");
`endif

endmodule

// ===== src/plucked_string_voice_bank.sv =====
// ----------------------------------------------------------------------------
// plucked_string_voice_bank: bank of plucked-string voices
// Round-robin pluck allocation, per-sample voice advance and mix output,
// run by a microcoded sequencer over a delay memory with one read and one
// write port.
// ----------------------------------------------------------------------------
// A pluck item (mode 1) refills the next voice in round-robin order with
// period_length noise samples, clamped to LOOP_DEPTH, and returns no item.
// A tick item (mode 0) advances each live voice by one sample and returns one
// item: mix_in plus all voice samples, saturated to 20 bits. The delay memory
// has one write port and one registered read port, and each sounding voice
// needs two reads and one write. After acceptance a tick steps through a
// dispatch, then per sounding voice a read of the current slot, a read of
// the next slot, a multiply and a write, per silent voice a length check and
// a skip, then the emit into the output register and a return to idle.
// A pluck steps through a start, one memory write per sample of the clamped
// length and a done step, then idle. Only one item is in flight at a time; the
// result sits in an output register, so the next item can be taken while
// the previous result is still stalled, unless a tick finishes before the
// previous result leaves, in which case the sequencer waits. The delay
// memory has no clearing pass; a voice only reads slots its last pluck wrote.
// decay_gain is written through the configuration channel, which is always
// ready, and should only be written while the block is idle.
module plucked_string_voice_bank #(
  parameter int VOICES      = psvb_pkg::VOICES_DEF,
  parameter int LOOP_DEPTH  = psvb_pkg::LOOP_DEPTH_DEF,
  parameter int NOISE_DEPTH = psvb_pkg::NOISE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [psvb_pkg::PLEN_W-1:0]          period_length,
  input  logic signed [psvb_pkg::SAMPLE_W-1:0] mix_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [psvb_pkg::MIX_W-1:0]    mix_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psvb_pkg::GAIN_W-1:0]          cfg_decay_gain
);
  import psvb_pkg::*;

  ops_t              ops;
  status_t           status;
  logic [GAIN_W-1:0] decay_gain;

  // The gain register accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      decay_gain <= cfg_decay_gain;
    end
  end

  psvb_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ops    (ops)
  );

  psvb_dpath #(
    .VOICES      (VOICES),
    .LOOP_DEPTH  (LOOP_DEPTH),
    .NOISE_DEPTH (NOISE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ops           (ops),
    .status        (status),
    .decay_gain    (decay_gain),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .period_length (period_length),
    .mix_in        (mix_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mix_out       (mix_out)
  );

endmodule

// ===== test/tb_plucked_string_voice_bank.sv =====
// ----------------------------------------------------------------------------
// tb_plucked_string_voice_bank: self-checking bench for the string voice bank
// Drives pluck and tick items with random idling on both channels, keeps its
// own copy of every voice loop to predict each mix result, and compares every
// result as it leaves the block. The decay gain is changed between phases.
// ----------------------------------------------------------------------------
module tb_plucked_string_voice_bank;

  import psvb_pkg::*;

  localparam int VOICES      = VOICES_DEF;
  localparam int LOOP_DEPTH  = LOOP_DEPTH_DEF;
  localparam int NOISE_DEPTH = NOISE_DEPTH_DEF;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PLUCK = 1'b1;

  localparam int MIX_TOP    = (1 << (MIX_W - 1)) - 1;
  localparam int MIX_BOTTOM = -(1 << (MIX_W - 1));

  // A pluck returns nothing, so its fill of up to LOOP_DEPTH writes may still
  // be running after the last result has left. This many cycles covers it.
  localparam int FILL_TAIL   = LOOP_DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 17;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       mode           = MODE_TICK;
  logic [PLEN_W-1:0]          period_length  = '0;
  logic signed [SAMPLE_W-1:0] mix_in         = '0;
  logic                       out_stall      = 1'b0;
  logic                       cfg_valid      = 1'b0;
  logic [GAIN_W-1:0]          cfg_decay_gain = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic signed [MIX_W-1:0]    mix_out;
  logic                       cfg_ready;

  // Predicted state of the bank: one delay loop per voice, its length and read
  // position, the round-robin pluck pointer, the noise table and the gain.
  logic signed [SAMPLE_W-1:0] string_loop [VOICES][LOOP_DEPTH];
  int unsigned                loop_len    [VOICES];
  int unsigned                read_pos    [VOICES];
  int unsigned                pluck_voice;
  logic signed [SAMPLE_W-1:0] noise_seq   [NOISE_DEPTH];
  logic [GAIN_W-1:0]          decay_q;

  // Mix results still owed by the block, oldest first.
  logic signed [MIX_W-1:0]    mix_due [$];
  logic signed [MIX_W-1:0]    mix_want;

  // When clear, neither side idles, which packs items back to back.
  bit gaps_on = 1'b1;

  int err_count    = 0;
  int cycle_count  = 0;
  int pluck_count  = 0;
  int tick_count   = 0;
  int mix_checked  = 0;
  int gain_writes  = 0;

  plucked_string_voice_bank i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .period_length  (period_length),
    .mix_in         (mix_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mix_out        (mix_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_decay_gain (cfg_decay_gain)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog. A correct run ends far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycle_count, mix_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The result side stalls at random, except in the packed stretch.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Every result that leaves is matched against the oldest prediction.
  // Values read right after the edge are the ones the edge sampled.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (mix_due.size() == 0) begin
        $display("%0t: mix_out %0d arrived with no result expected", $time, mix_out);
        err_count++;
      end else begin
        mix_want = mix_due.pop_front();
        mix_checked++;
        if (mix_out !== mix_want) begin
          $display("%0t: mix_out expected %0d, actual %0d", $time, mix_want, mix_out);
          err_count++;
        end
      end
    end
  end

  // Bank state after reset. The noise table is the sequence of a 16-bit
  // Galois shift register, each word taken as signed and halved.
  function automatic void clear_bank();
    logic [15:0] shreg;
    logic        low_bit;
    shreg = LFSR_SEED;
    for (int i = 0; i < NOISE_DEPTH; i++) begin
      low_bit = shreg[0];
      shreg   = shreg >> 1;
      if (low_bit) begin
        shreg = shreg ^ LFSR_MASK;
      end
      noise_seq[i] = {shreg[15], shreg[15:1]};
    end
    for (int v = 0; v < VOICES; v++) begin
      loop_len[v] = 0;
      read_pos[v] = 0;
      for (int s = 0; s < LOOP_DEPTH; s++) begin
        string_loop[v][s] = '0;
      end
    end
    pluck_voice = 0;
    decay_q     = GAIN_RESET;
  endfunction

  // Loop feedback: the gain times the mean of two neighboring samples. The
  // arithmetic shift floors, and the result always fits in a sample.
  function automatic logic signed [SAMPLE_W-1:0] damped_mean(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0]          pair_sum;
    logic signed [SAMPLE_W+GAIN_W+1:0] product;
    pair_sum = a + b;
    product  = pair_sum * $signed({1'b0, decay_q});
    return SAMPLE_W'(product >>> 17);
  endfunction

  // A pluck refills the next voice from the noise table, wrapping the table
  // when the loop is longer, and clamps the length to the loop depth.
  function automatic void restring_voice(input logic [PLEN_W-1:0] len);
    int unsigned span;
    span = len;
    if (span > LOOP_DEPTH) begin
      span = LOOP_DEPTH;
    end
    for (int unsigned s = 0; s < span; s++) begin
      string_loop[pluck_voice][s] = noise_seq[s % NOISE_DEPTH];
    end
    loop_len[pluck_voice] = span;
    read_pos[pluck_voice] = 0;
    pluck_voice = (pluck_voice + 1) % VOICES;
  endfunction

  // A tick advances every sounding voice by one sample and returns the
  // saturated mix. The next slot is written before the current one is read,
  // so a loop of length one emits the value it has just damped.
  function automatic logic signed [MIX_W-1:0] advance_voices(
    input logic signed [SAMPLE_W-1:0] base_mix
  );
    int          acc;
    int unsigned cur;
    int unsigned nxt;
    acc = base_mix;
    for (int v = 0; v < VOICES; v++) begin
      if (loop_len[v] != 0) begin
        cur = read_pos[v];
        nxt = (cur + 1 >= loop_len[v]) ? 0 : cur + 1;
        string_loop[v][nxt] = damped_mean(string_loop[v][cur], string_loop[v][nxt]);
        acc += string_loop[v][cur];
        read_pos[v] = nxt;
      end
    end
    if (acc > MIX_TOP) begin
      acc = MIX_TOP;
    end else if (acc < MIX_BOTTOM) begin
      acc = MIX_BOTTOM;
    end
    return MIX_W'(acc);
  endfunction

  // Offers one item, waits for it to be taken, then updates the prediction.
  // Valid stays high on return so that the next item can follow directly.
  task automatic send_item(
    input logic                       m,
    input logic [PLEN_W-1:0]          len,
    input logic signed [SAMPLE_W-1:0] mx
  );
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    mode          <= m;
    period_length <= len;
    mix_in        <= mx;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (m == MODE_PLUCK) begin
      restring_voice(len);
      pluck_count++;
    end else begin
      mix_due.push_back(advance_voices(mx));
      tick_count++;
    end
  endtask

  task automatic send_random_item();
    int unsigned        pick;
    logic [PLEN_W-1:0]  len;
    pick = $urandom_range(99);
    len  = PLEN_W'($urandom);
    if (pick < 25) begin
      // Mostly short loops keep plucks cheap; a few run long or clamp.
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = PLEN_W'($urandom_range(64));
      end else if (pick < 95) begin
        len = PLEN_W'($urandom_range(LOOP_DEPTH));
      end else begin
        len = PLEN_W'($urandom_range((1 << PLEN_W) - 1, LOOP_DEPTH + 1));
      end
      send_item(MODE_PLUCK, len, SAMPLE_W'($urandom));
    end else begin
      send_item(MODE_TICK, len, SAMPLE_W'($urandom));
    end
  endtask

  // Drops valid, lets every owed result leave and gives a running fill time
  // to finish, so that the bank is idle afterwards.
  task automatic drain_bank();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mix_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (FILL_TAIL) @(posedge clk);
  endtask

  task automatic write_decay_gain(input logic [GAIN_W-1:0] gain);
    drain_bank();
    cfg_decay_gain <= gain;
    cfg_valid      <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    decay_q = gain;
    gain_writes++;
  endtask

  // Default gain: a silent voice, the two shortest loops and the mix extremes.
  task automatic test_silent_and_short_voices();
    send_item(MODE_PLUCK, PLEN_W'(0), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(1), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(2), SAMPLE_W'(0));
    send_item(MODE_TICK, PLEN_W'(0), 16'sh7FFF);
    send_item(MODE_TICK, PLEN_W'(0), 16'sh8000);
    send_item(MODE_TICK, PLEN_W'(0), SAMPLE_W'(0));
    send_item(MODE_TICK, {PLEN_W{1'b1}}, SAMPLE_W'($urandom));
  endtask

  // Clamped lengths, loops longer than the noise table, a full-depth loop and
  // plucks that carry a mix value they must ignore. The last pluck refills the
  // first voice again, after the round-robin pointer wraps.
  task automatic test_long_and_wrapping_plucks();
    send_item(MODE_PLUCK, {PLEN_W{1'b1}}, SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(LOOP_DEPTH + 1), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(NOISE_DEPTH + 44), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(LOOP_DEPTH), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(3), 16'shFFFF);
    send_item(MODE_PLUCK, PLEN_W'(5), 16'sh7FFF);
    send_item(MODE_TICK, PLEN_W'(0), 16'sh7FFF);
    send_item(MODE_TICK, PLEN_W'(0), 16'sh8000);
  endtask

  // Zero gain kills the loops after one pass; full gain keeps them ringing.
  task automatic test_gain_extremes();
    write_decay_gain('0);
    send_item(MODE_TICK, PLEN_W'(0), SAMPLE_W'(0));
    send_item(MODE_TICK, PLEN_W'(0), SAMPLE_W'(0));
    write_decay_gain('1);
    send_item(MODE_TICK, PLEN_W'(0), SAMPLE_W'(0));
    send_item(MODE_PLUCK, PLEN_W'(1), SAMPLE_W'(0));
    send_item(MODE_TICK, PLEN_W'(0), 16'sh7FFF);
    send_item(MODE_TICK, PLEN_W'(0), 16'sh8000);
  endtask

  // Random plucks and ticks under several gains, idling on both sides.
  task automatic test_random_traffic();
    logic [GAIN_W-1:0] gains [5];
    gains[0] = GAIN_W'($urandom);
    gains[1] = 16'h8000;
    gains[2] = '1;
    gains[3] = GAIN_W'($urandom_range(4095));
    gains[4] = GAIN_RESET;
    foreach (gains[g]) begin
      write_decay_gain(gains[g]);
      repeat (70) send_random_item();
    end
  endtask

  // A stretch with no idling on either side, so each item is offered as soon
  // as the block can take it and every result leaves as soon as it appears.
  task automatic test_back_to_back();
    write_decay_gain(GAIN_W'($urandom));
    gaps_on = 1'b0;
    repeat (50) send_random_item();
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_bank();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_silent_and_short_voices();
    test_long_and_wrapping_plucks();
    test_gain_extremes();
    test_random_traffic();
    test_back_to_back();
    drain_bank();

    $display("Ran %0d plucks and %0d ticks across %0d decay gain writes.",
             pluck_count, tick_count, gain_writes);
    $display("Compared %0d mix results, %0d mismatches.", mix_checked, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
